// File: sv/depth_pixel_colorizer_core_assert.svh
// assertion macros for the depth pixel colorizer
`ifndef DEPTH_PIXEL_COLORIZER_CORE_ASSERT_SVH
`define DEPTH_PIXEL_COLORIZER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition in this cycle implies consequence in the same cycle
`define DPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpc assertion failed");
// condition in this cycle implies consequence in the next cycle
`define DPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpc assertion failed");
`else
`define DPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/dpc_pkg.sv
package dpc_pkg;

  localparam int DPC_ROM_DEPTH = 16384;
  localparam int DPC_ROM_AW    = 14;
  localparam int DPC_ROM_W     = 8;

  localparam logic [13:0] DPC_LOW_LIMIT  = 14'd400;
  localparam logic [13:0] DPC_HIGH_LIMIT = 14'd16383;
  localparam logic [2:0]  DPC_MAX_PLAYER = 3'd6;

  // per-player right shifts, index 7 first
  localparam logic [7:0][1:0] DPC_SHIFT_R = {2'd0, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0};
  localparam logic [7:0][1:0] DPC_SHIFT_G = {2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0};
  localparam logic [7:0][1:0] DPC_SHIFT_B = {2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0};

  typedef struct packed {
    logic [15:0] depth_mm;
    logic [2:0]  player_index;
  } dpc_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } dpc_color_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [13:0] wdata;
  } dpc_cfg_t;

  localparam logic [1:0] DPC_CFG_MIN   = 2'd0;
  localparam logic [1:0] DPC_CFG_MAX   = 2'd1;
  localparam logic [1:0] DPC_CFG_TREAT = 2'd2;

  typedef enum logic [1:0] {
    DPC_TREAT_CLAMP  = 2'd0,
    DPC_TREAT_TINT   = 2'd1,
    DPC_TREAT_ALL    = 2'd2,
    DPC_TREAT_WINDOW = 2'd3
  } dpc_treat_e;

  typedef enum logic [2:0] {
    DPC_PIX_UNKNOWN,
    DPC_PIX_ZERO,
    DPC_PIX_WINDOW,
    DPC_PIX_FAR,
    DPC_PIX_NEAR
  } dpc_kind_e;

  typedef struct packed {
    dpc_kind_e  kind;
    dpc_treat_e mode;
    logic [2:0] player;
    logic       big;
  } dpc_class_t;

  typedef struct packed {
    logic                  we;
    logic [DPC_ROM_AW-1:0] addr;
    logic [DPC_ROM_W-1:0]  data;
  } dpc_rom_wr_t;

  localparam dpc_color_t DPC_UNKNOWN_COLOR = '{red: 8'h3F, green: 8'h3F, blue: 8'h07, alpha: 8'h00};
  localparam dpc_color_t DPC_NEAR_COLOR    = '{red: 8'h1F, green: 8'h7F, blue: 8'hFF, alpha: 8'h00};
  localparam dpc_color_t DPC_FAR_COLOR     = '{red: 8'h7F, green: 8'h0F, blue: 8'h3F, alpha: 8'h00};
  localparam dpc_color_t DPC_WHITE_COLOR   = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'h00};
  localparam dpc_color_t DPC_ZERO_COLOR    = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00};

  // log2(n) in q31, repeated squaring of the mantissa
  function automatic logic [63:0] dpc_log2_q31(input logic [31:0] n);
    int          p;
    int          i;
    logic [63:0] y;
    logic [63:0] frac;
    p    = 0;
    frac = '0;
    if (n == 32'd0) begin
      return '0;
    end
    while (p < 30 && (n >> (p + 1)) != 32'd0) begin
      p++;
    end
    y = {32'd0, n} << (31 - p);
    for (i = 30; i >= 0; i--) begin
      y = (y * y) >> 31;
      if ((y >> 32) != 64'd0) begin
        y       = y >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(p) << 31) | frac;
  endfunction

  // unclamped darkening level of depth d, d >= 400
  function automatic logic [63:0] dpc_curve_level(input int d);
    logic [63:0] diff;
    diff = dpc_log2_q31(32'(d + 100)) - dpc_log2_q31(32'd500);
    return (diff * 64'd860551918) >> 55;
  endfunction

  typedef logic [255:0][14:0] dpc_thresh_t;

  // smallest depth at which the level reaches k, 16384 if never
  function automatic dpc_thresh_t dpc_build_thresh();
    dpc_thresh_t t;
    int          k;
    int          lo;
    int          hi;
    int          mid;
    for (k = 0; k < 256; k++) begin
      lo = 400;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (dpc_curve_level(mid) >= 64'(k)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      t[k] = 15'(lo);
    end
    return t;
  endfunction

  localparam dpc_thresh_t DPC_THRESH = dpc_build_thresh();

endpackage

// File: sv/dpc_stream_if.sv
interface dpc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/dpc_ram.sv
module dpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: sv/dpc_rom_fill.sv
module dpc_rom_fill (
  input  logic                 clk,
  input  logic                 rst_n,
  output dpc_pkg::dpc_rom_wr_t wr,
  output logic                 done
);
  import dpc_pkg::*;

  logic [DPC_ROM_AW-1:0] addr_r, addr_nxt;
  logic [7:0]            level_r, level_nxt;
  logic                  done_r, done_nxt;
  logic                  step;

  // the curve darkens by at most one level per mm
  always_comb begin
    step      = (level_r != 8'hFF) &&
                ({1'b0, addr_r} >= DPC_THRESH[level_r + 8'd1]);
    level_nxt = level_r + {7'd0, step};
    addr_nxt  = addr_r;
    done_nxt  = done_r;
    if (!done_r) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == {DPC_ROM_AW{1'b1}}) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      level_r <= '0;
      done_r  <= 1'b0;
    end else begin
      addr_r  <= addr_nxt;
      done_r  <= done_nxt;
      if (!done_r) begin
        level_r <= level_nxt;
      end
    end
  end

  assign wr.we   = !done_r;
  assign wr.addr = addr_r;
  assign wr.data = 8'hFF - level_nxt;
  assign done    = done_r;
endmodule

// File: sv/dpc_color_map.sv
module dpc_color_map (
  input  dpc_pkg::dpc_class_t cls,
  input  logic [7:0]          rom_q,
  output dpc_pkg::dpc_color_t color
);
  import dpc_pkg::*;

  logic [7:0] inten;

  always_comb begin
    inten = cls.big ? 8'hFF : rom_q;
    color = DPC_ZERO_COLOR;
    unique case (cls.kind)
      DPC_PIX_UNKNOWN: color = DPC_UNKNOWN_COLOR;
      DPC_PIX_ZERO:    color = DPC_ZERO_COLOR;
      DPC_PIX_WINDOW: begin
        color.red   = inten >> DPC_SHIFT_R[cls.player];
        color.green = inten >> DPC_SHIFT_G[cls.player];
        color.blue  = inten >> DPC_SHIFT_B[cls.player];
        color.alpha = 8'hFF;
      end
      DPC_PIX_FAR: begin
        unique case (cls.mode)
          DPC_TREAT_CLAMP: color = DPC_FAR_COLOR;
          DPC_TREAT_TINT:  color = '{red: inten, green: inten >> 3, blue: inten >> 1,
                                     alpha: 8'hFF};
          DPC_TREAT_ALL:    color = DPC_ZERO_COLOR;
          DPC_TREAT_WINDOW: color = DPC_ZERO_COLOR;
          default:          color = DPC_ZERO_COLOR;
        endcase
      end
      DPC_PIX_NEAR: begin
        unique case (cls.mode)
          DPC_TREAT_CLAMP: color = DPC_NEAR_COLOR;
          DPC_TREAT_TINT:  color = '{red: inten >> 3, green: inten >> 1, blue: inten,
                                     alpha: 8'hFF};
          DPC_TREAT_ALL:    color = DPC_WHITE_COLOR;
          DPC_TREAT_WINDOW: color = DPC_ZERO_COLOR;
          default:          color = DPC_ZERO_COLOR;
        endcase
      end
      default: color = DPC_ZERO_COLOR;
    endcase
  end
endmodule

// File: sv/depth_pixel_colorizer_core.sv
// depth pixel colorizer: maps one depth pixel to one rgba color
// in_ch carries depth_mm and player_index, out_ch carries red, green, blue, alpha,
// cfg_ch writes reliable_min_depth (0), reliable_max_depth (1), treatment mode (2);
// writes to any other index are dropped, cfg_ch is always ready
// after reset the log intensity curve is written into a 16384 x 8 memory, one entry
// per cycle; in_ch.ready stays low until the fill is done, config writes still land
// throughput: one pixel per cycle while out_ch.ready is high, set by the single read port of the curve memory
// an input beat passes through the memory read stage, then the output register, on its
// way to the output beat
// when out_ch.ready is low the output beat holds and one more pixel waits in the read
// stage; in_ch.ready then drops until the output beat is taken
// reset (rst_n low, synchronous) empties the pipeline and restores the registers to
// 800, 4000 and clamp mode
`include "depth_pixel_colorizer_core_assert.svh"

module depth_pixel_colorizer_core #(
  parameter logic [2:0] MAX_PLAYER = dpc_pkg::DPC_MAX_PLAYER
) (
  input logic   clk,
  input logic   rst_n,
  dpc_stream_if.sink   in_ch,
  dpc_stream_if.source out_ch,
  dpc_stream_if.sink   cfg_ch
);
  import dpc_pkg::*;

  // configuration registers
  logic [13:0] min_r;
  logic [13:0] max_r;
  dpc_treat_e  treat_r;

  // pipeline control
  logic       s1_v_r, s1_v_nxt;
  logic       out_v_r, out_v_nxt;
  dpc_class_t s1_cls_r;
  dpc_color_t out_data_r;
  dpc_class_t cls_nxt;
  dpc_color_t color;
  logic       adv;
  logic       in_acc;
  logic       fill_done;

  // curve memory signals
  dpc_rom_wr_t     rom_wr;
  logic [7:0]      rom_q;
  dpc_pixel_t      pix;
  logic            fill_run;

  logic [13:0] win_lo;
  logic [13:0] win_hi;
  logic        in_win;
  logic        is_far;

  // config write port, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= 14'd800;
      max_r   <= 14'd4000;
      treat_r <= DPC_TREAT_CLAMP;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.reg_index)
        DPC_CFG_MIN:   min_r   <= cfg_ch.data.wdata;
        DPC_CFG_MAX:   max_r   <= cfg_ch.data.wdata;
        DPC_CFG_TREAT: treat_r <= dpc_treat_e'(cfg_ch.data.wdata[1:0]);
        default: ;
      endcase
    end
  end

  // the output register frees up when empty or taken
  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = fill_done && (!s1_v_r || adv);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign pix          = in_ch.data;

  // classify the pixel on the way in; the memory read runs in parallel
  always_comb begin
    if (treat_r == DPC_TREAT_ALL) begin
      win_lo = DPC_LOW_LIMIT;
      win_hi = DPC_HIGH_LIMIT;
    end else begin
      win_lo = min_r;
      win_hi = max_r;
    end
    in_win = (pix.depth_mm >= {2'b00, win_lo}) && (pix.depth_mm <= {2'b00, win_hi});
    is_far = pix.depth_mm > {2'b00, win_hi};

    cls_nxt.mode   = treat_r;
    cls_nxt.player = pix.player_index;
    cls_nxt.big    = pix.depth_mm > {2'b00, DPC_HIGH_LIMIT};
    if (pix.depth_mm == 16'd0) begin
      // unknown depth, only no-player pixels get the marker color
      cls_nxt.kind = (pix.player_index == 3'd0) ? DPC_PIX_UNKNOWN : DPC_PIX_ZERO;
    end else if (in_win) begin
      cls_nxt.kind = (pix.player_index <= MAX_PLAYER) ? DPC_PIX_WINDOW : DPC_PIX_ZERO;
    end else if (pix.player_index != 3'd0) begin
      cls_nxt.kind = DPC_PIX_ZERO;
    end else if (is_far) begin
      // far wins when the window is empty
      cls_nxt.kind = DPC_PIX_FAR;
    end else begin
      cls_nxt.kind = DPC_PIX_NEAR;
    end
  end

  // curve memory fill after reset
  dpc_rom_fill u_fill (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (rom_wr),
    .done (fill_done)
  );

  // fill sweep still has entries ahead of it
  assign fill_run = rom_wr.we && !(&rom_wr.addr);

  // intensity curve memory, read data held while the read stage stalls
  dpc_ram #(
    .WIDTH(DPC_ROM_W),
    .DEPTH(DPC_ROM_DEPTH)
  ) u_rom (
    .clk  (clk),
    .we   (rom_wr.we),
    .waddr(rom_wr.addr),
    .wdata(rom_wr.data),
    .re   (in_acc),
    .raddr(pix.depth_mm[DPC_ROM_AW-1:0]),
    .rdata(rom_q)
  );

  dpc_color_map u_map (
    .cls  (s1_cls_r),
    .rom_q(rom_q),
    .color(color)
  );

  always_comb begin
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    out_v_nxt = adv ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cls_r <= cls_nxt;
    end
    if (adv && s1_v_r) begin
      out_data_r <= color;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  // no pixel enters before the curve memory is complete
  `DPC_ASSERT_NOW(a_no_accept_during_fill, clk, rst_n, in_ch.valid && in_ch.ready, fill_done)
  // an accepted pixel is in the read stage next cycle
  `DPC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_acc, s1_v_r)
  // a stalled read stage keeps its pixel
  `DPC_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_v_r && !adv, s1_v_r && $stable(s1_cls_r))
  // the fill sweep walks the memory one entry per cycle
  `DPC_ASSERT_NEXT(a_fill_walk, clk, rst_n, fill_run, rom_wr.addr == ($past(rom_wr.addr) + 1'b1))
endmodule

// File: verif/depth_pixel_colorizer_core_tb.sv
module depth_pixel_colorizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpc_pkg::*;

  // curve limits and fixed colors, kept independent of the package copies
  localparam logic [13:0] CURVE_FLOOR = 14'd400;
  localparam logic [13:0] CURVE_TOP   = 14'd16383;
  localparam logic [2:0]  LAST_PLAYER = 3'd6;
  localparam logic [63:0] LN2_X74_Q24 = 64'd860551918;

  // register index past the end of the register list
  localparam logic [1:0]  NO_REGISTER = 2'd3;

  localparam dpc_color_t COLOR_UNKNOWN = '{red: 8'h3F, green: 8'h3F, blue: 8'h07, alpha: 8'h00};
  localparam dpc_color_t COLOR_NEAR    = '{red: 8'h1F, green: 8'h7F, blue: 8'hFF, alpha: 8'h00};
  localparam dpc_color_t COLOR_FAR     = '{red: 8'h7F, green: 8'h0F, blue: 8'h3F, alpha: 8'h00};
  localparam dpc_color_t COLOR_WHITE   = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'h00};
  localparam dpc_color_t COLOR_BLACK   = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00};

  // per-player right shifts of red, green, blue
  localparam logic [1:0] PLAYER_SHR_R [0:7] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0};
  localparam logic [1:0] PLAYER_SHR_G [0:7] = '{2'd0, 2'd2, 2'd2, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] PLAYER_SHR_B [0:7] = '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd2, 2'd0, 2'd0};

  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int PRINT_CAP       = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dpc_stream_if #(.T(dpc_pixel_t)) in_ch ();
  dpc_stream_if #(.T(dpc_color_t)) out_ch ();
  dpc_stream_if #(.T(dpc_cfg_t))   cfg_ch ();

  depth_pixel_colorizer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // local copy of the intensity curve and of the registers
  logic [7:0]  curve_rom [0:16383];
  logic [13:0] win_min;
  logic [13:0] win_max;
  dpc_treat_e  win_mode;

  dpc_pixel_t pending_pixels [$];
  dpc_color_t expected_colors [$];
  int         mismatches = 0;

  // sender state
  logic hold_sender = 1'b0;
  logic in_took = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  // receiver state
  int stall_style = 0;
  int stall_span = 0;
  int stall_tick = 0;

  // log2 of n in q31: top set bit as integer part, fraction by repeated squaring
  function automatic logic [63:0] log2_fixed(input logic [31:0] n);
    int          top;
    int          b;
    logic [63:0] m;
    logic [63:0] acc;
    top = 0;
    acc = '0;
    for (b = 0; b <= 30; b++) begin
      if (n[b]) begin
        top = b;
      end
    end
    m = 64'(n) << (31 - top);
    for (b = 30; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m[63:32] != 32'd0) begin
        m      = m >> 1;
        acc[b] = 1'b1;
      end
    end
    return (64'(top) << 31) | acc;
  endfunction

  // expected color of one pixel under the current register settings
  function automatic dpc_color_t predict_color(input dpc_pixel_t px);
    logic [13:0] lo;
    logic [13:0] hi;
    logic [7:0]  lvl;
    logic [2:0]  pl;
    dpc_color_t  c;
    lo  = win_min;
    hi  = win_max;
    pl  = px.player_index;
    c   = COLOR_BLACK;
    if (win_mode == DPC_TREAT_ALL) begin
      lo = CURVE_FLOOR;
      hi = CURVE_TOP;
    end
    lvl = (px.depth_mm > 16'(CURVE_TOP)) ? 8'hFF : curve_rom[px.depth_mm[13:0]];
    if (px.depth_mm == 16'd0) begin
      // unknown depth only gets its color without a player
      if (pl == 3'd0) begin
        c = COLOR_UNKNOWN;
      end
    end else if (px.depth_mm >= 16'(lo) && px.depth_mm <= 16'(hi)) begin
      if (pl <= LAST_PLAYER) begin
        c = '{red: lvl >> PLAYER_SHR_R[pl], green: lvl >> PLAYER_SHR_G[pl],
              blue: lvl >> PLAYER_SHR_B[pl], alpha: 8'hFF};
      end
    end else if (pl == 3'd0) begin
      // far wins over near, which matters for an empty window
      if (px.depth_mm > 16'(hi)) begin
        case (win_mode)
          DPC_TREAT_CLAMP: c = COLOR_FAR;
          DPC_TREAT_TINT:  c = '{red: lvl, green: lvl >> 3, blue: lvl >> 1, alpha: 8'hFF};
          default:         c = COLOR_BLACK;
        endcase
      end else begin
        case (win_mode)
          DPC_TREAT_CLAMP: c = COLOR_NEAR;
          DPC_TREAT_TINT:  c = '{red: lvl >> 3, green: lvl >> 1, blue: lvl, alpha: 8'hFF};
          DPC_TREAT_ALL:   c = COLOR_WHITE;
          default:         c = COLOR_BLACK;
        endcase
      end
    end
    return c;
  endfunction

  // random pixel, weighted toward the window edges and the curve limits
  function automatic dpc_pixel_t random_pixel();
    dpc_pixel_t px;
    int         sel;
    int         base;
    int         d;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      d = 0;
    end else if (sel < 50) begin
      case ($urandom_range(0, 4))
        0: base = int'(win_min);
        1: base = int'(win_max);
        2: base = int'(CURVE_FLOOR);
        3: base = int'(CURVE_TOP);
        default: base = 16384;
      endcase
      d = base + $urandom_range(0, 6) - 3;
      if (d < 0) begin
        d = 0;
      end
    end else if (sel < 80) begin
      d = $urandom_range(1, 16383);
    end else if (sel < 90) begin
      d = $urandom_range(16384, 65535);
    end else begin
      d = $urandom_range(0, 65535);
    end
    px.depth_mm     = 16'(d);
    px.player_index = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
    return px;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // one register write beat; the local copy follows at the same edge
  task automatic write_register(input logic [1:0] idx, input logic [13:0] value);
    @(negedge clk);
    cfg_ch.data  <= '{reg_index: idx, wdata: value};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      DPC_CFG_MIN:   win_min = value;
      DPC_CFG_MAX:   win_max = value;
      DPC_CFG_TREAT: win_mode = dpc_treat_e'(value[1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || expected_colors.size() != 0) begin
      @(posedge clk);
    end
    // extra wait so the pipeline is surely empty
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of beats with random gaps, valid held until the beat is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (in_took) begin
        in_took = 1'b0;
        burst_left--;
      end
      if (burst_left <= 0) begin
        if ($urandom_range(0, 7) == 0) begin
          // stretch with no idling
          burst_left = $urandom_range(100, 300);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(0, 6);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (!hold_sender && pending_pixels.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_pixels[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: ready follows a stall style that changes every stretch
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 4);
      stall_span  = $urandom_range(16, 200);
    end else begin
      stall_span--;
    end
    stall_tick++;
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      3: out_ch.ready <= (stall_tick % 3 == 0);
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // predictor on every accepted pixel beat, checker on every color beat
  always @(posedge clk) begin
    dpc_color_t got;
    dpc_color_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_colors.push_back(predict_color(in_ch.data));
        void'(pending_pixels.pop_front());
        in_took = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("color beat %h with nothing expected", got));
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red) begin
            report_mismatch($sformatf("red got %h want %h", got.red, want.red));
          end
          if (got.green !== want.green) begin
            report_mismatch($sformatf("green got %h want %h", got.green, want.green));
          end
          if (got.blue !== want.blue) begin
            report_mismatch($sformatf("blue got %h want %h", got.blue, want.blue));
          end
          if (got.alpha !== want.alpha) begin
            report_mismatch($sformatf("alpha got %h want %h", got.alpha, want.alpha));
          end
        end
      end
    end
  end

  // stimulus: directed pixels under reset settings, then random phases
  initial begin
    int          p;
    int          i;
    int          d;
    logic [13:0] lo;
    logic [13:0] hi;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    win_min  = 14'd800;
    win_max  = 14'd4000;
    win_mode = DPC_TREAT_CLAMP;

    // intensity curve: flat white below the floor, log darkening above
    for (d = 0; d < 16384; d++) begin
      logic [63:0] lvl64;
      if (d < int'(CURVE_FLOOR)) begin
        curve_rom[d] = 8'hFF;
      end else begin
        lvl64 = ((log2_fixed(32'(d + 100)) - log2_fixed(32'd500)) * LN2_X74_Q24) >> 55;
        curve_rom[d] = (lvl64 > 64'd255) ? 8'd0 : 8'(64'd255 - lvl64);
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: unknown depth, depth limits, window edges, every player
    pending_pixels.push_back('{depth_mm: 16'd0, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd0, player_index: 3'd3});
    pending_pixels.push_back('{depth_mm: 16'd0, player_index: 3'd7});
    pending_pixels.push_back('{depth_mm: 16'hFFFF, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'hFFFF, player_index: 3'd5});
    pending_pixels.push_back('{depth_mm: 16'd16384, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd16383, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd400, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd399, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd1, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd799, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd800, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd4000, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd4001, player_index: 3'd0});
    pending_pixels.push_back('{depth_mm: 16'd4001, player_index: 3'd2});
    for (i = 0; i < 8; i++) begin
      pending_pixels.push_back('{depth_mm: 16'd2000, player_index: 3'(i)});
    end
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      // window shape cycles through ordinary, full, empty and single-depth
      case (p / 4)
        0: begin
          lo = 14'($urandom_range(1, 8000));
          hi = 14'($urandom_range(int'(lo), 16383));
        end
        1: begin
          lo = 14'($urandom_range(0, 1));
          hi = CURVE_TOP;
        end
        2: begin
          if (p % 2 == 0) begin
            lo = CURVE_TOP;
            hi = 14'd1;
          end else begin
            hi = 14'($urandom_range(1, 8000));
            lo = 14'($urandom_range(int'(hi) + 1, 16383));
          end
        end
        default: begin
          lo = (p % 2 == 0) ? CURVE_TOP : 14'($urandom_range(1, 16383));
          hi = lo;
        end
      endcase
      write_register(DPC_CFG_MIN, lo);
      write_register(DPC_CFG_MAX, hi);
      // upper bits of the mode write are random and must be dropped
      write_register(DPC_CFG_TREAT, {12'($urandom()), 2'(p % 4)});
      // unused index, must not disturb anything
      write_register(NO_REGISTER, 14'($urandom()));

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        pending_pixels.push_back(random_pixel());
      end
      if (p == 6) begin
        // hold the sender until every color owed has come out
        while (pending_pixels.size() > ITEMS_PER_PHASE / 2) begin
          @(posedge clk);
        end
        @(negedge clk);
        hold_sender <= 1'b1;
        while (expected_colors.size() != 0) begin
          @(posedge clk);
        end
        @(negedge clk);
        hold_sender <= 1'b0;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run including the curve fill
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
